@@ src/rk4_pkg.sv @@
// rk4 integrator package: register file map, micro-op format and step program
// used by the sequencer and the shared multiplier; no dependencies
package rk4_pkg;

    // configuration register indexes
    localparam logic CFG_STEP_SIZE  = 1'b0;
    localparam logic CFG_STEP_COUNT = 1'b1;

    // register file map
    localparam int RF_DEPTH = 12;
    localparam int RF_AW    = 4;

    localparam logic [RF_AW-1:0] R_U     = 4'd0;
    localparam logic [RF_AW-1:0] R_V     = 4'd1;
    localparam logic [RF_AW-1:0] R_AU    = 4'd2;
    localparam logic [RF_AW-1:0] R_AV    = 4'd3;
    localparam logic [RF_AW-1:0] R_KU    = 4'd4;
    localparam logic [RF_AW-1:0] R_KV    = 4'd5;
    localparam logic [RF_AW-1:0] R_SU    = 4'd6;
    localparam logic [RF_AW-1:0] R_SV    = 4'd7;
    localparam logic [RF_AW-1:0] R_T     = 4'd8;
    localparam logic [RF_AW-1:0] R_H     = 4'd9;
    localparam logic [RF_AW-1:0] R_HALF  = 4'd10;
    localparam logic [RF_AW-1:0] R_SIXTH = 4'd11;

    // micro-op codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_NEG = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // program counter over one rk4 step
    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_LAST = 6'd43;

    typedef struct packed {
        logic [1:0]       op;
        logic [RF_AW-1:0] dst;
        logic [RF_AW-1:0] src_a;
        logic [RF_AW-1:0] src_b;
    } t_uop;

    // multiplier status toward the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } t_mul_stat;

    function automatic t_uop mk_uop(input logic [1:0] op, input logic [RF_AW-1:0] d,
                                    input logic [RF_AW-1:0] a, input logic [RF_AW-1:0] b);
        t_uop u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        return u;
    endfunction

    // one rk4 step; k1 lands in the running sums, k2..k4 in the k registers
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            // k1 = h*f(u, v)
            6'd0:  u = mk_uop(OP_MUL, R_T,  R_U,    R_V);
            6'd1:  u = mk_uop(OP_MUL, R_SU, R_H,    R_T);
            6'd2:  u = mk_uop(OP_MUL, R_T,  R_U,    R_U);
            6'd3:  u = mk_uop(OP_NEG, R_T,  R_T,    R_T);
            6'd4:  u = mk_uop(OP_MUL, R_SV, R_H,    R_T);
            // y + k1/2
            6'd5:  u = mk_uop(OP_MUL, R_T,  R_HALF, R_SU);
            6'd6:  u = mk_uop(OP_ADD, R_AU, R_U,    R_T);
            6'd7:  u = mk_uop(OP_MUL, R_T,  R_HALF, R_SV);
            6'd8:  u = mk_uop(OP_ADD, R_AV, R_V,    R_T);
            // k2
            6'd9:  u = mk_uop(OP_MUL, R_T,  R_AU,   R_AV);
            6'd10: u = mk_uop(OP_MUL, R_KU, R_H,    R_T);
            6'd11: u = mk_uop(OP_MUL, R_T,  R_AU,   R_AU);
            6'd12: u = mk_uop(OP_NEG, R_T,  R_T,    R_T);
            6'd13: u = mk_uop(OP_MUL, R_KV, R_H,    R_T);
            // sum += 2*k2
            6'd14: u = mk_uop(OP_ADD, R_T,  R_KU,   R_KU);
            6'd15: u = mk_uop(OP_ADD, R_SU, R_SU,   R_T);
            6'd16: u = mk_uop(OP_ADD, R_T,  R_KV,   R_KV);
            6'd17: u = mk_uop(OP_ADD, R_SV, R_SV,   R_T);
            // y + k2/2
            6'd18: u = mk_uop(OP_MUL, R_T,  R_HALF, R_KU);
            6'd19: u = mk_uop(OP_ADD, R_AU, R_U,    R_T);
            6'd20: u = mk_uop(OP_MUL, R_T,  R_HALF, R_KV);
            6'd21: u = mk_uop(OP_ADD, R_AV, R_V,    R_T);
            // k3
            6'd22: u = mk_uop(OP_MUL, R_T,  R_AU,   R_AV);
            6'd23: u = mk_uop(OP_MUL, R_KU, R_H,    R_T);
            6'd24: u = mk_uop(OP_MUL, R_T,  R_AU,   R_AU);
            6'd25: u = mk_uop(OP_NEG, R_T,  R_T,    R_T);
            6'd26: u = mk_uop(OP_MUL, R_KV, R_H,    R_T);
            // sum += 2*k3
            6'd27: u = mk_uop(OP_ADD, R_T,  R_KU,   R_KU);
            6'd28: u = mk_uop(OP_ADD, R_SU, R_SU,   R_T);
            6'd29: u = mk_uop(OP_ADD, R_T,  R_KV,   R_KV);
            6'd30: u = mk_uop(OP_ADD, R_SV, R_SV,   R_T);
            // y + k3
            6'd31: u = mk_uop(OP_ADD, R_AU, R_U,    R_KU);
            6'd32: u = mk_uop(OP_ADD, R_AV, R_V,    R_KV);
            // k4
            6'd33: u = mk_uop(OP_MUL, R_T,  R_AU,   R_AV);
            6'd34: u = mk_uop(OP_MUL, R_KU, R_H,    R_T);
            6'd35: u = mk_uop(OP_MUL, R_T,  R_AU,   R_AU);
            6'd36: u = mk_uop(OP_NEG, R_T,  R_T,    R_T);
            6'd37: u = mk_uop(OP_MUL, R_KV, R_H,    R_T);
            // sum += k4
            6'd38: u = mk_uop(OP_ADD, R_SU, R_SU,   R_KU);
            6'd39: u = mk_uop(OP_ADD, R_SV, R_SV,   R_KV);
            // y += sum/6
            6'd40: u = mk_uop(OP_MUL, R_T,  R_SIXTH, R_SU);
            6'd41: u = mk_uop(OP_ADD, R_U,  R_U,    R_T);
            6'd42: u = mk_uop(OP_MUL, R_T,  R_SIXTH, R_SV);
            6'd43: u = mk_uop(OP_ADD, R_V,  R_V,    R_T);
            default: u = mk_uop(OP_NEG, R_T, R_T,   R_T);
        endcase
        return u;
    endfunction

endpackage

@@ src/rk4_ode_integrator_unit.sv @@
// rk4 integrator top level: configuration registers, step sequencer and
// saturating adder; depends on rk4_pkg, rk4_regs and rk4_mul
//
//  channel   ports                                     direction
//  config    i_cfg_we, i_cfg_idx, i_cfg_data           in, write at any edge with we
//  command   start, busy, i_initial_u, i_initial_v     in, transfer when start & !busy
//  result    o_valid, o_final_u, o_final_v, o_saturated out, one-cycle strobe
//
// one item runs from its transfer through the load sweep, step_count rk4 steps of
// 44 micro-ops each and the read-out to the result strobe; each product takes ND =
// ceil(DATA_WIDTH / digit) multiplier digits (1 at 32 bits); the shared multiplier
// and the single register file write port pace the run
// reset is synchronous, active low, and restores the config registers
// busy stays high from the transfer until the result strobe has gone
// the result is shown for one cycle only; the receiver cannot stall it
module rk4_ode_integrator_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [30:0]                   i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [DATA_WIDTH-1:0]  i_initial_u,
    input  logic signed [DATA_WIDTH-1:0]  i_initial_v,
    output logic                          o_valid,
    output logic signed [DATA_WIDTH-1:0]  o_final_u,
    output logic signed [DATA_WIDTH-1:0]  o_final_v,
    output logic                          o_saturated
);
    import rk4_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int HW = (W > 31) ? W : 31;

    localparam logic [W-1:0]  MAX_V     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MIN_V     = {1'b1, {(W-1){1'b0}}};
    localparam logic [63:0]   MAX64     = (64'd1 << (W - 1)) - 64'd1;
    localparam logic [63:0]   HALF_RAW  = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0]   SIXTH_RAW = ((64'd1 << FRAC_BITS) + 64'd3) / 64'd6;
    localparam logic [W-1:0]  HALF_C    = W'((HALF_RAW > MAX64) ? MAX64 : HALF_RAW);
    localparam logic [W-1:0]  SIXTH_C   = W'((SIXTH_RAW > MAX64) ? MAX64 : SIXTH_RAW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_RDOUT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [2:0] LD_LAST = 3'd4;

    logic [30:0]     r_step_size;
    logic [15:0]     r_step_count;
    logic [2:0]      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [15:0]     r_steps_left, n_steps_left;
    logic [2:0]      r_ld, n_ld;
    logic            r_sat, n_sat;
    logic [W-1:0]    r_in_u, r_in_v;

    t_uop             w_uop;
    logic [HW-1:0]    w_step_ext;
    logic             w_h_sat;
    logic [W-1:0]     w_h;
    logic             w_we;
    logic [RF_AW-1:0] w_wa, w_ra_a, w_ra_b;
    logic [W-1:0]     w_wd, w_rd_a, w_rd_b;
    logic [W:0]       w_sum;
    logic             w_ovf;
    logic [W-1:0]     w_alu;
    logic             w_alu_sat;
    logic             w_mul_start;
    logic [W-1:0]     w_mul_res;
    t_mul_stat        w_mul_stat;
    logic             w_advance;

    assign w_uop = uop_rom(r_pc);

    // step size clamped to the signed range
    assign w_step_ext = HW'(r_step_size);
    assign w_h_sat    = (w_step_ext > HW'(MAX_V));
    assign w_h        = w_h_sat ? MAX_V : W'(w_step_ext);

    // saturating add and negate
    assign w_sum = {w_rd_a[W-1], w_rd_a} + {w_rd_b[W-1], w_rd_b};
    assign w_ovf = w_sum[W] ^ w_sum[W-1];

    always_comb begin
        if (w_uop.op == OP_NEG) begin
            w_alu_sat = (w_rd_a == MIN_V);
            w_alu     = w_alu_sat ? MAX_V : (W'(0) - w_rd_a);
        end else begin
            w_alu_sat = w_ovf;
            w_alu     = w_ovf ? (w_sum[W] ? MIN_V : MAX_V) : w_sum[W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size  <= 31'd536870912;
            r_step_count <= 16'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_SIZE:  r_step_size  <= i_cfg_data;
                CFG_STEP_COUNT: r_step_count <= i_cfg_data[15:0];
                default:        r_step_size  <= r_step_size;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_pc         = r_pc;
        n_steps_left = r_steps_left;
        n_ld         = r_ld;
        n_sat        = r_sat;
        w_we         = 1'b0;
        w_wa         = w_uop.dst;
        w_wd         = w_alu;
        w_ra_a       = w_uop.src_a;
        w_ra_b       = w_uop.src_b;
        w_mul_start  = 1'b0;
        w_advance    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_sat        = w_h_sat;
                    n_steps_left = r_step_count;
                    n_ld         = '0;
                    n_state      = S_INIT;
                end
            end
            S_INIT: begin
                w_we = 1'b1;
                unique case (r_ld)
                    3'd0: begin
                        w_wa = R_U;
                        w_wd = r_in_u;
                    end
                    3'd1: begin
                        w_wa = R_V;
                        w_wd = r_in_v;
                    end
                    3'd2: begin
                        w_wa = R_H;
                        w_wd = w_h;
                    end
                    3'd3: begin
                        w_wa = R_HALF;
                        w_wd = HALF_C;
                    end
                    default: begin
                        w_wa = R_SIXTH;
                        w_wd = SIXTH_C;
                    end
                endcase
                n_ld = r_ld + 3'd1;
                if (r_ld == LD_LAST) begin
                    n_pc    = '0;
                    n_state = (r_steps_left == 16'd0) ? S_RDOUT : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_uop.op == OP_MUL) begin
                    w_mul_start = 1'b1;
                    n_state     = S_WAIT;
                end else begin
                    w_we      = 1'b1;
                    n_sat     = r_sat | w_alu_sat;
                    w_advance = 1'b1;
                end
            end
            S_WAIT: begin
                if (w_mul_stat.done) begin
                    w_we      = 1'b1;
                    w_wd      = w_mul_res;
                    n_sat     = r_sat | w_mul_stat.sat;
                    w_advance = 1'b1;
                end
            end
            S_RDOUT: begin
                w_ra_a  = R_U;
                w_ra_b  = R_V;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next micro-op, next step or read-out
        if (w_advance) begin
            if (r_pc == PC_LAST) begin
                n_pc         = '0;
                n_steps_left = r_steps_left - 16'd1;
                n_state      = (r_steps_left == 16'd1) ? S_RDOUT : S_FETCH;
            end else begin
                n_pc    = r_pc + PC_W'(1);
                n_state = S_FETCH;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pc         <= '0;
            r_steps_left <= '0;
            r_ld         <= '0;
            r_sat        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pc         <= n_pc;
            r_steps_left <= n_steps_left;
            r_ld         <= n_ld;
            r_sat        <= n_sat;
        end
    end

    // starting state held for the load sweep
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_in_u <= i_initial_u;
            r_in_v <= i_initial_v;
        end
    end

    rk4_regs #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regs (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_wa   (w_wa),
        .i_wd   (w_wd),
        .i_ra_a (w_ra_a),
        .i_ra_b (w_ra_b),
        .o_rd_a (w_rd_a),
        .o_rd_b (w_rd_b)
    );

    rk4_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_rd_a),
        .i_b     (w_rd_b),
        .o_res   (w_mul_res),
        .o_stat  (w_mul_stat)
    );

    // result transfer straight from the read registers
    assign busy        = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_DONE);
    assign o_final_u   = w_rd_a;
    assign o_final_v   = w_rd_b;
    assign o_saturated = r_sat;

endmodule

@@ src/rk4_regs.sv @@
// rk4 integrator register file: one write port, two registered read ports
// depends on rk4_pkg for the register file depth and address width
module rk4_regs #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [rk4_pkg::RF_AW-1:0]    i_wa,
    input  logic [DATA_WIDTH-1:0]        i_wd,
    input  logic [rk4_pkg::RF_AW-1:0]    i_ra_a,
    input  logic [rk4_pkg::RF_AW-1:0]    i_ra_b,
    output logic [DATA_WIDTH-1:0]        o_rd_a,
    output logic [DATA_WIDTH-1:0]        o_rd_b
);
    import rk4_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [RF_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_rd_a <= r_mem[i_ra_a];
        o_rd_b <= r_mem[i_ra_b];
    end

endmodule

@@ src/rk4_mul.sv @@
// rk4 integrator shared multiplier: digit-serial magnitude multiply, then
// round half away from zero and saturate; depends on rk4_pkg for t_mul_stat
module rk4_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DATA_WIDTH-1:0]   i_a,
    input  logic [DATA_WIDTH-1:0]   i_b,
    output logic [DATA_WIDTH-1:0]   o_res,
    output rk4_pkg::t_mul_stat      o_stat
);
    import rk4_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int DIG  = (W <= 32) ? W : 16;
    localparam int ND   = (W + DIG - 1) / DIG;
    localparam int PW   = ND * DIG;
    localparam int CNTW = $clog2(ND + 1);
    localparam int SW   = (2 * W >= FRAC_BITS) ? 2 * W + 1 : FRAC_BITS + 1;
    localparam int QW   = SW - FRAC_BITS;
    localparam int CW   = (QW > W) ? QW : W;

    localparam logic [W-1:0]    MAX_V    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]    MIN_V    = {1'b1, {(W-1){1'b0}}};
    localparam logic [SW-1:0]   RND      = SW'(1) << (FRAC_BITS - 1);
    localparam logic [W+PW-1:0] LOW_MASK = ((W+PW)'(1) << (PW - DIG)) - (W+PW)'(1);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_RND  = 2'd2;
    localparam logic [1:0] M_FIN  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [W-1:0]    r_ua, n_ua;
    logic [W+PW-1:0] r_p, n_p;
    logic            r_neg, n_neg;
    logic [SW-1:0]   r_s, n_s;

    logic [W-1:0]     w_ua, w_ub;
    logic [DIG-1:0]   w_dig;
    logic [W+DIG-1:0] w_sum;
    logic [QW-1:0]    w_q;
    logic [CW-1:0]    w_q_ext, w_lim;
    logic             w_sat;

    // operand magnitudes
    assign w_ua = i_a[W-1] ? (W'(0) - i_a) : i_a;
    assign w_ub = i_b[W-1] ? (W'(0) - i_b) : i_b;

    // one digit of the multiplier per cycle into the upper half
    assign w_dig = r_p[DIG-1:0];
    assign w_sum = (W+DIG)'(r_p[W+PW-1:PW]) + r_ua * w_dig;

    // rounded quotient and saturation check
    assign w_q     = r_s[SW-1:FRAC_BITS];
    assign w_q_ext = CW'(w_q);
    assign w_lim   = CW'(MAX_V) + CW'(r_neg);
    assign w_sat   = (w_q_ext > w_lim);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ua    = r_ua;
        n_p     = r_p;
        n_neg   = r_neg;
        n_s     = r_s;
        o_res   = r_neg ? W'(CW'(0) - w_q_ext) : W'(w_q_ext);
        o_stat  = '{done: 1'b0, sat: 1'b0};
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_ua    = w_ua;
                    n_p     = {{W{1'b0}}, PW'(w_ub)};
                    n_neg   = i_a[W-1] ^ i_b[W-1];
                    n_cnt   = '0;
                    n_state = M_RUN;
                end
            end
            M_RUN: begin
                n_p   = (((W+PW)'(w_sum)) << (PW - DIG)) | ((r_p >> DIG) & LOW_MASK);
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(ND - 1)) begin
                    n_state = M_RND;
                end
            end
            M_RND: begin
                n_s     = SW'(r_p[2*W-1:0]) + RND;
                n_state = M_FIN;
            end
            M_FIN: begin
                o_stat.done = 1'b1;
                o_stat.sat  = w_sat;
                if (w_sat) begin
                    o_res = r_neg ? MIN_V : MAX_V;
                end
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ua  <= n_ua;
        r_p   <= n_p;
        r_neg <= n_neg;
        r_s   <= n_s;
    end

endmodule

@@ test/testbench.sv @@
// self-checking bench for rk4_ode_integrator_unit: drives start/busy commands,
// predicts final (u, v) and the saturation flag with its own fixed-point rk4
// integrator; depends on rk4_pkg and the unit under test
`timescale 1ns / 100ps

module testbench;

    import rk4_pkg::*;

    localparam int DW = 32;
    localparam int FB = 28;

    typedef logic signed [DW-1:0] t_fix;

    typedef struct {
        t_fix u;
        t_fix v;
        logic sat;
    } t_final;

    localparam longint FIX_MAX = (longint'(1) << (DW - 1)) - 1;
    localparam longint FIX_MIN = -FIX_MAX - 1;
    localparam longint HALF_C  = longint'(1) << (FB - 1);
    localparam longint SIXTH_C = ((longint'(1) << FB) + 3) / 6;
    localparam t_fix   FX_ONE  = t_fix'(longint'(1) << FB);
    localparam t_fix   FX_MAX  = t_fix'(FIX_MAX);
    localparam t_fix   FX_MIN  = t_fix'(FIX_MIN);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [30:0] i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    t_fix        i_initial_u = '0;
    t_fix        i_initial_v = '0;
    logic        o_valid;
    t_fix        o_final_u;
    t_fix        o_final_v;
    logic        o_saturated;

    // predictor copy of the configuration registers
    logic [30:0] step_size_cfg;
    logic [15:0] step_count_cfg;
    bit          sat_seen;

    t_final expected_finals[$];
    int     errors = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     configs_applied = 0;
    int     send_idle_pct = 0;

    rk4_ode_integrator_unit #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_initial_u (i_initial_u),
        .i_initial_v (i_initial_v),
        .o_valid     (o_valid),
        .o_final_u   (o_final_u),
        .o_final_v   (o_final_v),
        .o_saturated (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // saturating fixed-point arithmetic, sticky flag in sat_seen
    function automatic longint fx_clamp(input longint x);
        if (x > FIX_MAX) begin
            sat_seen = 1'b1;
            return FIX_MAX;
        end
        if (x < FIX_MIN) begin
            sat_seen = 1'b1;
            return FIX_MIN;
        end
        return x;
    endfunction

    function automatic longint fx_add(input longint a, input longint b);
        return fx_clamp(a + b);
    endfunction

    function automatic longint fx_neg(input longint a);
        return fx_clamp(-a);
    endfunction

    // exact product, magnitude rounded half away from zero, then clamped
    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned ma, mb, q;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        q = (ma * mb + longint'(HALF_C)) >> FB;
        if (neg) begin
            if (q > longint'(FIX_MAX) + 1) begin
                sat_seen = 1'b1;
                return FIX_MIN;
            end
            return -longint'(q);
        end
        if (q > longint'(FIX_MAX)) begin
            sat_seen = 1'b1;
            return FIX_MAX;
        end
        return longint'(q);
    endfunction

    // h * f(u, v) with f = (u*v, -(u*u))
    function automatic void slope(input longint h, input longint u, input longint v,
                                  output longint du, output longint dv);
        du = fx_mul(h, fx_mul(u, v));
        dv = fx_mul(h, fx_neg(fx_mul(u, u)));
    endfunction

    function automatic t_final integrate(input t_fix u0, input t_fix v0);
        longint u, v, h, su, sv;
        longint k1u, k1v, k2u, k2v, k3u, k3v, k4u, k4v;
        t_final r;
        sat_seen = 1'b0;
        u = u0;
        v = v0;
        h = longint'({1'b0, step_size_cfg});
        for (int unsigned n = 0; n < step_count_cfg; n++) begin
            slope(h, u, v, k1u, k1v);
            slope(h, fx_add(u, fx_mul(HALF_C, k1u)), fx_add(v, fx_mul(HALF_C, k1v)),
                  k2u, k2v);
            slope(h, fx_add(u, fx_mul(HALF_C, k2u)), fx_add(v, fx_mul(HALF_C, k2v)),
                  k3u, k3v);
            slope(h, fx_add(u, k3u), fx_add(v, k3v), k4u, k4v);
            su = fx_add(fx_add(fx_add(k1u, fx_add(k2u, k2u)), fx_add(k3u, k3u)), k4u);
            sv = fx_add(fx_add(fx_add(k1v, fx_add(k2v, k2v)), fx_add(k3v, k3v)), k4v);
            u = fx_add(u, fx_mul(SIXTH_C, su));
            v = fx_add(v, fx_mul(SIXTH_C, sv));
        end
        r.u = t_fix'(u);
        r.v = t_fix'(v);
        r.sat = sat_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        if (errors <= 40)
            $display("mismatch on %s at %0t ns: got %h expected %h", what, $time, got, want);
    endtask

    // result checker: every strobe pops the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_final want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_finals.size() == 0) begin
                report_mismatch("unexpected result u", o_final_u, 0);
            end else begin
                want = expected_finals.pop_front();
                if (o_final_u !== want.u)
                    report_mismatch("final_u", o_final_u, want.u);
                if (o_final_v !== want.v)
                    report_mismatch("final_v", o_final_v, want.v);
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", o_saturated, want.sat);
            end
        end
    end

    function automatic bit sender_idles();
        return $urandom_range(0, 99) < send_idle_pct;
    endfunction

    // one command transfer; start is left high so back-to-back items need no gap
    task automatic send_item(input t_fix u, input t_fix v);
        bit accepted;
        i_initial_u <= u;
        i_initial_v <= v;
        start <= !sender_idles();
        do begin
            @(posedge i_clk);
            accepted = start && !busy;
            if (!accepted)
                start <= !sender_idles();
        end while (!accepted);
        expected_finals.insert(expected_finals.size(), integrate(u, v));
        items_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_finals.size() != 0 || busy);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_STEP_SIZE)
            step_size_cfg = data;
        else
            step_count_cfg = data[15:0];
        @(posedge i_clk);
    endtask

    // only called with the unit idle; junk in the unused count bits
    task automatic set_config(input logic [30:0] h, input logic [15:0] n);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_STEP_SIZE, h);
        write_reg(CFG_STEP_COUNT, {15'($urandom), n});
        configs_applied++;
    endtask

    // mostly modest magnitudes, some full-range noise and corner values
    function automatic t_fix pick_fix();
        case ($urandom_range(0, 9))
            0, 1: return t_fix'($urandom);
            2: begin
                case ($urandom_range(0, 5))
                    0: return FX_MIN;
                    1: return FX_MAX;
                    2: return '0;
                    3: return FX_ONE;
                    4: return -FX_ONE;
                    default: return -1;
                endcase
            end
            default: return t_fix'($signed($urandom) >>> $urandom_range(2, 8));
        endcase
    endfunction

    // reset values: h = 2.0, five steps
    task automatic test_reset_defaults();
        send_item(FX_ONE, FX_ONE >>> 1);
        send_item(FX_ONE >>> 3, -(FX_ONE >>> 2));
        drain();
    endtask

    task automatic test_field_extremes();
        set_config(31'h0200_0000, 16'd1);
        send_item(FX_MIN, FX_MIN);
        send_item(FX_MAX, FX_MAX);
        send_item(FX_MIN, FX_MAX);
        send_item(FX_MAX, FX_MIN);
        send_item('0, '0);
        send_item(-1, -1);
        send_item(1, 1);
        send_item(FX_ONE, -FX_ONE);
        drain();
    endtask

    // zero step count passes the inputs through untouched
    task automatic test_zero_steps();
        set_config(31'h1000_0000, 16'd0);
        send_item(FX_MIN, FX_MAX);
        send_item(FX_MAX, FX_MIN);
        send_item(t_fix'(123), t_fix'(-5));
        drain();
    endtask

    task automatic test_step_size_extremes();
        set_config(31'h0, 16'd3);
        send_item(FX_ONE, FX_ONE);
        send_item(FX_MIN, FX_MAX);
        drain();
        set_config(31'h7fff_ffff, 16'd2);
        send_item(FX_ONE >>> 1, FX_ONE >>> 2);
        send_item(FX_MAX, FX_MAX);
        drain();
    endtask

    // largest step count, tiny step so the state stays in range
    task automatic test_longest_run();
        set_config(31'h0000_1000, 16'hffff);
        send_item(FX_ONE >>> 1, -(FX_ONE >>> 1));
        drain();
    endtask

    task automatic test_random_traffic(input int idle_pct);
        logic [30:0] h;
        logic [15:0] n;
        send_idle_pct = idle_pct;
        for (int g = 0; g < 5; g++) begin
            case ($urandom_range(0, 7))
                0: h = ($urandom_range(0, 1) == 0) ? 31'h0 : 31'h7fff_ffff;
                1: h = 31'($urandom);
                default: h = 31'($urandom_range(32'h0040_0000, 32'h0800_0000));
            endcase
            n = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(5, 24))
                                            : 16'($urandom_range(1, 4));
            set_config(h, n);
            for (int k = 0; k < 130; k++) begin
                send_item(pick_fix(), pick_fix());
                // hold off until the unit has returned everything
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
            drain();
        end
    endtask

    initial begin
        step_size_cfg = 31'h2000_0000;
        step_count_cfg = 16'd5;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        test_reset_defaults();
        test_field_extremes();
        test_zero_steps();
        test_step_size_extremes();
        test_longest_run();
        test_random_traffic(9);
        test_random_traffic(58);
        test_random_traffic(0);

        repeat (20) @(posedge i_clk);
        $display("covered %0d commands over %0d register settings, %0d results checked",
                 items_sent, configs_applied, results_seen);
        $display("incl. zero and 65535 steps, zero and full step size, saturating inputs");
        if (errors == 0 && expected_finals.size() == 0)
            $display("rk4_ode_integrator_unit test passed");
        else
            $display("rk4_ode_integrator_unit test failed");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #1_000_000_000;
        $display("rk4_ode_integrator_unit test failed");
        $finish;
    end

endmodule
